>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on a clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// mbsp_pkg
// Constants, types and helpers of the MIDI byte stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbsp_pkg;

  localparam int unsigned SYSEX_DEPTH = 64;
  localparam int unsigned SYSEX_AW    = $clog2(SYSEX_DEPTH);

  localparam logic [7:0] SOX_BYTE     = 8'hF0;
  localparam logic [7:0] EOX_BYTE     = 8'hF7;
  localparam logic [7:0] NO_STATUS    = 8'h00;
  localparam logic [3:0] PROG_CHANGE  = 4'hC;
  localparam logic [3:0] CHAN_PRESS   = 4'hD;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_CH_STAT  = 7'b0000010,
    ST_CH_FIRST = 7'b0000100,
    ST_CH_LAST  = 7'b0001000,
    ST_SX_RD    = 7'b0010000,
    ST_SX_DAT   = 7'b0100000,
    ST_SX_END   = 7'b1000000
  } state_e;

  // Status codes whose message carries a single data byte.
  function automatic logic one_data(input logic [7:0] status);
    logic [3:0] hi;
    hi = status[7:4];
    return (hi == PROG_CHANGE) || (hi == CHAN_PRESS);
  endfunction

endpackage

>>> hdl/mbsp_in_if.sv
// ----------------------------------------------------------------------------
// mbsp_in_if
// Input channel: one received MIDI byte per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

>>> hdl/mbsp_out_if.sv
// ----------------------------------------------------------------------------
// mbsp_out_if
// Output channel: one byte of a completed message per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_last;
  logic       is_sysex;

  modport source (output valid, output out_byte, output is_last, output is_sysex,
                  input ready);
  modport sink   (input valid, input out_byte, input is_last, input is_sysex,
                  output ready);
endinterface

>>> hdl/midi_byte_stream_parser_core.sv
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_core
// MIDI parser with running status; sysex bytes are captured in a RAM and
// replayed as one run ending in F7 when the message closes.
// ----------------------------------------------------------------------------
//  channel | dir | payload                      | handshake
//  in_i    | in  | in_byte[7:0]                 | valid/ready
//  out_o   | out | out_byte[7:0], is_last, is_sysex | valid/ready
//
//  An input byte is taken only when the parser is idle.
//  A channel message then drains at one output word per cycle (2 or 3).
//  A sysex close drains each buffered byte through ST_SX_RD and ST_SX_DAT,
//  then sends F7. Output words sit in a register, so draining stalls
//  only while out_o is not ready. Reset is asynchronous and clears the
//  control state; the capture RAM needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module midi_byte_stream_parser_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  mbsp_in_if.sink          in_i,
  mbsp_out_if.source       out_o
);

  localparam int unsigned AW = mbsp_pkg::SYSEX_AW;
  localparam logic [AW-1:0] FILL_MAX = AW'(mbsp_pkg::SYSEX_DEPTH - 1);

  mbsp_pkg::state_e state_q, state_d;
  logic [7:0]    status_q, status_d;
  logic          cnt_q, cnt_d;
  logic [7:0]    first_q, first_d;
  logic [7:0]    data_q, data_d;
  logic          two_q, two_d;
  logic          sx_act_q, sx_act_d;
  logic [AW-1:0] fill_q, fill_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;
  logic          out_sx_q, out_sx_d;

  logic          can_load;
  logic          in_acc;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_rdata;

  mbsp_ram #(
    .DEPTH (mbsp_pkg::SYSEX_DEPTH),
    .WIDTH (8),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.in_byte),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign can_load    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == mbsp_pkg::ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    cnt_d      = cnt_q;
    first_d    = first_q;
    data_d     = data_q;
    two_d      = two_q;
    sx_act_d   = sx_act_q;
    fill_d     = fill_q;
    rd_idx_d   = rd_idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    out_sx_d   = out_sx_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = fill_q;

    unique case (state_q)
      mbsp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_i.in_byte == mbsp_pkg::SOX_BYTE) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            sx_act_d  = 1'b1;
            fill_d    = AW'(1);
          end else if (sx_act_q) begin
            if (in_i.in_byte == mbsp_pkg::EOX_BYTE) begin
              sx_act_d = 1'b0;
              rd_idx_d = '0;
              state_d  = mbsp_pkg::ST_SX_RD;
            end else if (fill_q < FILL_MAX) begin
              ram_we = 1'b1;
              fill_d = fill_q + AW'(1);
            end
          end else if (in_i.in_byte[7]) begin
            status_d = in_i.in_byte;
            cnt_d    = 1'b0;
          end else if (status_q != mbsp_pkg::NO_STATUS) begin
            if (mbsp_pkg::one_data(status_q)) begin
              data_d  = in_i.in_byte;
              two_d   = 1'b0;
              cnt_d   = 1'b0;
              state_d = mbsp_pkg::ST_CH_STAT;
            end else if (!cnt_q) begin
              first_d = in_i.in_byte;
              cnt_d   = 1'b1;
            end else begin
              data_d  = in_i.in_byte;
              two_d   = 1'b1;
              cnt_d   = 1'b0;
              state_d = mbsp_pkg::ST_CH_STAT;
            end
          end
        end
      end
      mbsp_pkg::ST_CH_STAT: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_byte_d  = status_q;
          out_last_d  = 1'b0;
          out_sx_d    = 1'b0;
          state_d     = two_q ? mbsp_pkg::ST_CH_FIRST : mbsp_pkg::ST_CH_LAST;
        end
      end
      mbsp_pkg::ST_CH_FIRST: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_byte_d  = first_q;
          out_last_d  = 1'b0;
          out_sx_d    = 1'b0;
          state_d     = mbsp_pkg::ST_CH_LAST;
        end
      end
      mbsp_pkg::ST_CH_LAST: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_byte_d  = data_q;
          out_last_d  = 1'b1;
          out_sx_d    = 1'b0;
          state_d     = mbsp_pkg::ST_IDLE;
        end
      end
      mbsp_pkg::ST_SX_RD: begin
        ram_re  = 1'b1;
        state_d = mbsp_pkg::ST_SX_DAT;
      end
      mbsp_pkg::ST_SX_DAT: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_byte_d  = ram_rdata;
          out_last_d  = 1'b0;
          out_sx_d    = 1'b1;
          rd_idx_d    = rd_idx_q + AW'(1);
          state_d     = (rd_idx_q == fill_q - AW'(1)) ? mbsp_pkg::ST_SX_END
                                                      : mbsp_pkg::ST_SX_RD;
        end
      end
      mbsp_pkg::ST_SX_END: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_byte_d  = mbsp_pkg::EOX_BYTE;
          out_last_d  = 1'b1;
          out_sx_d    = 1'b1;
          fill_d      = '0;
          state_d     = mbsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mbsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbsp_pkg::ST_IDLE;
      status_q    <= mbsp_pkg::NO_STATUS;
      cnt_q       <= 1'b0;
      two_q       <= 1'b0;
      sx_act_q    <= 1'b0;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      cnt_q       <= cnt_d;
      two_q       <= two_d;
      sx_act_q    <= sx_act_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q    <= first_d;
    data_q     <= data_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_sx_q   <= out_sx_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.is_last  = out_last_q;
  assign out_o.is_sysex = out_sx_q;

  `ASSERT_RST(a_sx_end_f7, clk_i, rst_ni, (out_o.valid && out_o.is_sysex && out_o.is_last) |-> (out_o.out_byte == mbsp_pkg::EOX_BYTE), "sysex run must end in F7")
  `ASSERT_RST(a_drain_nonempty, clk_i, rst_ni, (state_q == mbsp_pkg::ST_SX_RD) |-> (fill_q != '0), "sysex drain with empty buffer")
  `ASSERT_RST(a_rd_then_dat, clk_i, rst_ni, (state_q == mbsp_pkg::ST_SX_RD) |=> (state_q == mbsp_pkg::ST_SX_DAT), "RAM read not followed by data stage")
  `ASSERT_RST(a_no_wr_in_drain, clk_i, rst_ni, ram_we |-> (state_q == mbsp_pkg::ST_IDLE && !ram_re), "RAM write during drain")

endmodule

>>> hdl/mbsp_ram.sv
// ----------------------------------------------------------------------------
// mbsp_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbsp_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
